FILE: hdl/pbq_pkg.sv
package pbq_pkg;

  // coefficient registers are fixed signed 32 bit words
  localparam int COEF_BITS = 32;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  // register map, byte address is four times the index
  typedef enum logic [2:0] {
    REG_INPUT_GAIN = 3'd0,
    REG_COEF_B0    = 3'd1,
    REG_COEF_A1    = 3'd2,
    REG_COEF_B2    = 3'd3,
    REG_COEF_A2    = 3'd4
  } pbq_reg_index_t;

  // reset values of the coefficient set
  localparam logic signed [COEF_BITS-1:0] RESET_INPUT_GAIN = 32'sd1048576;
  localparam logic signed [COEF_BITS-1:0] RESET_COEF_B0    = 32'sd11752012;
  localparam logic signed [COEF_BITS-1:0] RESET_COEF_A1    = 32'sd0;
  localparam logic signed [COEF_BITS-1:0] RESET_COEF_B2    = -32'sd10353909;
  localparam logic signed [COEF_BITS-1:0] RESET_COEF_A2    = 32'sd349525;

  // coefficient set handed from the register file to the datapath
  typedef struct packed {
    logic signed [COEF_BITS-1:0] input_gain;
    logic signed [COEF_BITS-1:0] coef_b0;
    logic signed [COEF_BITS-1:0] coef_a1;
    logic signed [COEF_BITS-1:0] coef_b2;
    logic signed [COEF_BITS-1:0] coef_a2;
  } pbq_coefs_t;

endpackage

FILE: hdl/pbq_round_sat.sv
module pbq_round_sat #(
  parameter int IN_BITS = 59,
  parameter int SHIFT = 20,
  parameter int OUT_BITS = 24
) (
  input  logic signed [IN_BITS-1:0]  value,
  output logic signed [OUT_BITS-1:0] result,
  output logic                       sat
);

  localparam int SCALED_BITS = IN_BITS + 1 - SHIFT;
  localparam logic [IN_BITS:0] HALF = (IN_BITS + 1)'(1) << (SHIFT - 1);
  localparam logic [OUT_BITS-1:0] MAX_VAL = {1'b0, {(OUT_BITS - 1){1'b1}}};
  localparam logic [OUT_BITS-1:0] MIN_VAL = {1'b1, {(OUT_BITS - 1){1'b0}}};

  logic [IN_BITS:0]                   rounded;
  logic [SCALED_BITS-1:0]             scaled;
  logic [SCALED_BITS-OUT_BITS:0]      upper;
  logic                               in_range;

  // add one half lsb then floor, ties go towards plus infinity
  assign rounded  = {value[IN_BITS-1], value} + HALF;
  assign scaled   = rounded[IN_BITS:SHIFT];

  // in range when every bit above the output sign matches it
  assign upper    = scaled[SCALED_BITS-1:OUT_BITS-1];
  assign in_range = (&upper) | ~(|upper);

  assign sat    = ~in_range;
  assign result = in_range ? $signed(scaled[OUT_BITS-1:0])
                : (scaled[SCALED_BITS-1] ? $signed(MIN_VAL) : $signed(MAX_VAL));

endmodule

FILE: hdl/pbq_regs.sv
module pbq_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbq_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [pbq_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [pbq_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output pbq_pkg::pbq_coefs_t                 coefs
);
  import pbq_pkg::*;

  pbq_reg_index_t reg_index;
  logic           wr_en;

  assign pready    = 1'b1;
  assign reg_index = pbq_reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en     = psel & penable & pwrite & pready;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.input_gain <= RESET_INPUT_GAIN;
      coefs.coef_b0    <= RESET_COEF_B0;
      coefs.coef_a1    <= RESET_COEF_A1;
      coefs.coef_b2    <= RESET_COEF_B2;
      coefs.coef_a2    <= RESET_COEF_A2;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_INPUT_GAIN: coefs.input_gain <= $signed(pwdata);
        REG_COEF_B0:    coefs.coef_b0    <= $signed(pwdata);
        REG_COEF_A1:    coefs.coef_a1    <= $signed(pwdata);
        REG_COEF_B2:    coefs.coef_b2    <= $signed(pwdata);
        REG_COEF_A2:    coefs.coef_a2    <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_index)
      REG_INPUT_GAIN: prdata = coefs.input_gain;
      REG_COEF_B0:    prdata = coefs.coef_b0;
      REG_COEF_A1:    prdata = coefs.coef_a1;
      REG_COEF_B2:    prdata = coefs.coef_b2;
      REG_COEF_A2:    prdata = coefs.coef_a2;
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hdl/pbq_gain_stage.sv
module pbq_gain_stage #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample,
  input  logic                                    in_block_start,
  input  logic signed [pbq_pkg::COEF_BITS-1:0]    input_gain,
  input  logic                                    advance,
  output logic                                    gained_valid,
  output logic signed [SAMPLE_BITS-1:0]           gained_sample,
  output logic                                    gained_block_start
);
  import pbq_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

  logic signed [PROD_BITS-1:0]   product;
  logic signed [SAMPLE_BITS-1:0] gained;
  logic                          gain_sat;
  logic                          load;

  // stage is free when empty or when its item moves on this cycle
  assign in_ready = ~gained_valid | advance;
  assign load     = in_valid & in_ready;

  // input gain, rounded and clamped to the sample range
  assign product = in_sample * input_gain;

  pbq_round_sat #(
    .IN_BITS  (PROD_BITS),
    .SHIFT    (COEF_FRAC_BITS),
    .OUT_BITS (SAMPLE_BITS)
  ) u_gain_round (
    .value  (product),
    .result (gained),
    .sat    (gain_sat)
  );

  // gain clamping is not reported
  logic unused_gain_sat;
  assign unused_gain_sat = gain_sat;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gained_valid <= 1'b0;
    end else if (in_ready) begin
      gained_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      gained_sample      <= gained;
      gained_block_start <= in_block_start;
    end
  end

endmodule

FILE: hdl/pbq_biquad_core.sv
module pbq_biquad_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pbq_pkg::pbq_coefs_t                  coefs,
  input  logic                                 gained_valid,
  input  logic signed [SAMPLE_BITS-1:0]        gained_sample,
  input  logic                                 gained_block_start,
  output logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample,
  output logic                                 out_clipped
);
  import pbq_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS = PROD_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] past_input_one;
  logic signed [SAMPLE_BITS-1:0] past_input_two;
  logic signed [SAMPLE_BITS-1:0] past_output_one;
  logic signed [SAMPLE_BITS-1:0] past_output_two;
  logic signed [SAMPLE_BITS-1:0] x1;
  logic signed [SAMPLE_BITS-1:0] x2;
  logic signed [PROD_BITS-1:0]   prod_b0;
  logic signed [PROD_BITS-1:0]   prod_x1;
  logic signed [PROD_BITS-1:0]   prod_b2;
  logic signed [PROD_BITS-1:0]   prod_y2;
  logic signed [PROD_BITS-1:0]   prod_y1;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [SAMPLE_BITS-1:0] y0;
  logic                          y0_sat;
  logic                          step;

  // whole pipeline moves unless the result register is held
  assign advance = ~out_valid | out_ready;
  assign step    = advance & gained_valid;

  // block start drops the input history for this sample
  assign x1 = gained_block_start ? '0 : past_input_one;
  assign x2 = gained_block_start ? '0 : past_input_two;

  // five products in parallel, a1 serves both first delays
  assign prod_b0 = gained_sample * coefs.coef_b0;
  assign prod_x1 = x1 * coefs.coef_a1;
  assign prod_b2 = x2 * coefs.coef_b2;
  assign prod_y2 = past_output_two * coefs.coef_a2;
  assign prod_y1 = past_output_one * coefs.coef_a1;

  // exact sum
  assign acc = ACC_BITS'(prod_b0) + ACC_BITS'(prod_x1) + ACC_BITS'(prod_b2)
             - ACC_BITS'(prod_y2) - ACC_BITS'(prod_y1);

  pbq_round_sat #(
    .IN_BITS  (ACC_BITS),
    .SHIFT    (COEF_FRAC_BITS),
    .OUT_BITS (SAMPLE_BITS)
  ) u_out_round (
    .value  (acc),
    .result (y0),
    .sat    (y0_sat)
  );

  // filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      past_input_one  <= '0;
      past_input_two  <= '0;
      past_output_one <= '0;
      past_output_two <= '0;
    end else if (step) begin
      past_input_one  <= gained_sample;
      past_input_two  <= x1;
      past_output_one <= y0;
      past_output_two <= past_output_one;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= gained_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_sample  <= y0;
      out_clipped <= y0_sat;
    end
  end

`ifndef SYNTHESIS
  // a clipped result sits on one of the rails
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clipped) |->
      (out_sample == $signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}}) ||
       out_sample == $signed({1'b1, {(SAMPLE_BITS - 1){1'b0}}})))
    else $error("clipped result not saturated");

  // feedback history follows the result held for delivery
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (past_output_one == out_sample))
    else $error("output history out of step with result register");

  // an item leaving the gain stage lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("item lost between stages");

  // block start leaves no old input in the second delay
  assert property (@(posedge clk) disable iff (rst)
    (step && gained_block_start) |=> (past_input_two == '0))
    else $error("input history not cleared at block start");
`endif

endmodule

FILE: hdl/peaking_biquad_filter.sv
// peaking equaliser biquad, direct form one, one mono sample per transaction
//
// s_tdata carries the input sample, s_tuser the block start flag, which
// clears the input history (not the output history) before that sample.
// m_tdata carries the filtered sample, rounded and saturated; m_tuser is
// set when it was saturated. gain and coefficients are signed Q12.20
// words on the apb port (gain, b0, a1, b2, a2 at 0x0 to 0x10), to be
// written while no sample is in flight; the block does not enforce it.
//
// an accepted sample is registered in the gain register and then in
// the result register, which offers it on m_tvalid once the core
// advances. throughput: one sample per cycle while m_tready is high,
// set by the output feedback path, which is one multiply, the five-term
// sum and rounding, all combinational.
// when m_tready is low the result register holds and the gain stage
// still takes one more sample; with both full s_tready drops.
// reset clears the filter history to zero and loads the default
// coefficient set; nothing is in flight after reset.
module peaking_biquad_filter #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // stream in
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample_in
  input  logic                                 s_tuser,   // block_start
  // stream out
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // sample_out
  output logic                                 m_tuser,   // clipped
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pbq_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [pbq_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [pbq_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import pbq_pkg::*;

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  pbq_coefs_t                    coefs;
  logic                          advance;
  logic                          gained_valid;
  logic signed [SAMPLE_BITS-1:0] gained_sample;
  logic                          gained_block_start;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  // register file
  pbq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // input gain stage
  pbq_gain_stage #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_gain (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s_tvalid),
    .in_ready           (s_tready),
    .in_sample          ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .in_block_start     (s_tuser),
    .input_gain         (coefs.input_gain),
    .advance            (advance),
    .gained_valid       (gained_valid),
    .gained_sample      (gained_sample),
    .gained_block_start (gained_block_start)
  );

  // filter and result register
  pbq_biquad_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .coefs              (coefs),
    .gained_valid       (gained_valid),
    .gained_sample      (gained_sample),
    .gained_block_start (gained_block_start),
    .advance            (advance),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_sample         (out_sample),
    .out_clipped        (m_tuser)
  );

  // pad the result to whole bytes
  assign m_tdata = TDATA_BITS'($unsigned(out_sample));

endmodule
